>>> hdl/gdad_pkg.sv
`timescale 1ns / 1ps
// shared constants, widths and calendar helpers for the date adder
// no dependencies

package gdad_pkg;

	localparam int DAYS_WIDTH_DEF   = 30;
	localparam int YEAR_WIDTH_DEF   = 22;
	localparam int START_YEAR_WIDTH = 20;
	localparam int DAY_WIDTH        = 5;
	localparam int MONTH_WIDTH      = 4;
	// width of a linear day number for any start date
	localparam int DNUM_WIDTH       = 29;
	localparam int DOE_WIDTH        = 18;
	localparam int YOE_WIDTH        = 9;
	localparam int DOY_WIDTH        = 9;
	localparam int ERA_FWD_WIDTH    = 12;
	localparam int ERA_DAYS         = 146097;
	localparam int ERA_YEARS        = 400;
	localparam int YEAR_SHIFT       = 400;
	localparam int DAYS_PER_YEAR    = 365;
	localparam int DAYS_PER_QUAD    = 1460;
	localparam int DAYS_PER_CENT    = 36524;
	localparam int MONTHS           = 12;

	// first day of each month, counted from march 1
	function automatic logic [DOY_WIDTH-1:0] month_off(input logic [MONTH_WIDTH-1:0] mp);
		logic [DOY_WIDTH-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// yoe / 100 for yoe below 400
	function automatic logic [1:0] cent_of_yoe(input logic [YOE_WIDTH-1:0] yoe);
		logic [1:0] r;
		if (yoe >= 9'd300)
			r = 2'd3;
		else if (yoe >= 9'd200)
			r = 2'd2;
		else if (yoe >= 9'd100)
			r = 2'd1;
		else
			r = 2'd0;
		return r;
	endfunction

	// days before year yoe of the era
	function automatic logic [DOE_WIDTH-1:0] yoe_days(input logic [YOE_WIDTH-1:0] yoe);
		logic [DOE_WIDTH-1:0] r;
		r = DOE_WIDTH'(yoe) * DOE_WIDTH'(DAYS_PER_YEAR) + DOE_WIDTH'(yoe[YOE_WIDTH-1:2])
			- DOE_WIDTH'(cent_of_yoe(yoe));
		return r;
	endfunction

	// doe / 36524 for doe below one era
	function automatic logic [2:0] cent_of_doe(input logic [DOE_WIDTH-1:0] doe);
		logic [2:0] r;
		if (doe >= DOE_WIDTH'(4 * DAYS_PER_CENT))
			r = 3'd4;
		else if (doe >= DOE_WIDTH'(3 * DAYS_PER_CENT))
			r = 3'd3;
		else if (doe >= DOE_WIDTH'(2 * DAYS_PER_CENT))
			r = 3'd2;
		else if (doe >= DOE_WIDTH'(DAYS_PER_CENT))
			r = 3'd1;
		else
			r = 3'd0;
		return r;
	endfunction

	// march-based month index holding day of year doy
	function automatic logic [MONTH_WIDTH-1:0] month_of_doy(input logic [DOY_WIDTH-1:0] doy);
		logic [MONTH_WIDTH-1:0] r;
		r = '0;
		for (int i = 1; i < MONTHS; i++) begin
			if (doy >= month_off(MONTH_WIDTH'(i)))
				r = MONTH_WIDTH'(i);
		end
		return r;
	endfunction

endpackage

>>> hdl/gdad_if.sv
`timescale 1ns / 1ps
// valid/ready channels for the date adder: request and response
// depends on gdad_pkg

interface gdad_in_if #(
	parameter int DAYS_WIDTH = gdad_pkg::DAYS_WIDTH_DEF
);
	logic                                   valid;
	logic                                   ready;
	logic [DAYS_WIDTH-1:0]                  days_to_add;
	logic [gdad_pkg::DAY_WIDTH-1:0]         start_day;
	logic [gdad_pkg::MONTH_WIDTH-1:0]       start_month;
	logic [gdad_pkg::START_YEAR_WIDTH-1:0]  start_year;

	modport source (output valid, days_to_add, start_day, start_month, start_year,
		input ready);
	modport sink (input valid, days_to_add, start_day, start_month, start_year,
		output ready);
endinterface

interface gdad_out_if #(
	parameter int YEAR_WIDTH = gdad_pkg::YEAR_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic [gdad_pkg::DAY_WIDTH-1:0]    end_day;
	logic [gdad_pkg::MONTH_WIDTH-1:0]  end_month;
	logic [YEAR_WIDTH-1:0]             end_year;

	modport source (output valid, end_day, end_month, end_year, input ready);
	modport sink (input valid, end_day, end_month, end_year, output ready);
endinterface

>>> hdl/gdad_div.sv
`timescale 1ns / 1ps
// shared divider by the calendar constants: one multiplier gives a reciprocal estimate
// and its back product, then compare and subtract steps fix it; depends on gdad_pkg

module gdad_div #(
	parameter int NW = 31,
	parameter int VW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [VW-1:0] rem
);

	// era dividends are cut to their top bits before the estimate
	localparam int ERA_PRE = 17;
	localparam int ERA_SH  = NW - ERA_PRE;
	localparam int SMALL_W = 21;
	localparam int YEAR_SH = 29;
	localparam int QUAD_SH = 31;
	localparam int AW      = (ERA_SH > SMALL_W) ? ERA_SH : SMALL_W;
	localparam int PRW     = 2 * AW;
	localparam longint unsigned ERA_RCP  = (64'd1 << NW) / gdad_pkg::ERA_DAYS;
	localparam longint unsigned Y400_RCP = (64'd1 << YEAR_SH) / gdad_pkg::ERA_YEARS;
	localparam longint unsigned QUAD_RCP = (64'd1 << QUAD_SH) / gdad_pkg::DAYS_PER_QUAD;
	localparam longint unsigned Y365_RCP = (64'd1 << YEAR_SH) / gdad_pkg::DAYS_PER_YEAR;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_EST  = 2'd1;
	localparam logic [1:0] P_BACK = 2'd2;
	localparam logic [1:0] P_FIX  = 2'd3;

	logic [1:0]     phase_q;
	logic           done_q;
	logic [NW-1:0]  num_q;
	logic [VW-1:0]  dvs_q;
	logic [NW-1:0]  quo_q;
	logic [NW-1:0]  rem_q;
	logic [AW-1:0]  rcp;
	logic [AW-1:0]  num_cut;
	logic [AW-1:0]  mul_a;
	logic [AW-1:0]  mul_b;
	logic [PRW-1:0] prod;
	logic [NW-1:0]  est;
	logic           fix;

	always_comb begin
		num_cut = AW'(num_q);
		case (dvs_q)
			VW'(gdad_pkg::ERA_DAYS): begin
				rcp     = AW'(ERA_RCP);
				num_cut = AW'(num_q[NW-1:ERA_PRE]);
			end
			VW'(gdad_pkg::ERA_YEARS):     rcp = AW'(Y400_RCP);
			VW'(gdad_pkg::DAYS_PER_QUAD): rcp = AW'(QUAD_RCP);
			VW'(gdad_pkg::DAYS_PER_YEAR): rcp = AW'(Y365_RCP);
			default:                      rcp = '0;
		endcase
	end

	// the one multiplier: estimate first, then quotient times divisor
	always_comb begin
		if (phase_q == P_BACK) begin
			mul_a = quo_q[AW-1:0];
			mul_b = AW'(dvs_q);
		end else begin
			mul_a = num_cut;
			mul_b = rcp;
		end
		prod = PRW'(mul_a) * PRW'(mul_b);
	end

	// estimate never exceeds the true quotient
	always_comb begin
		case (dvs_q)
			VW'(gdad_pkg::ERA_DAYS):      est = NW'(prod >> ERA_SH);
			VW'(gdad_pkg::DAYS_PER_QUAD): est = NW'(prod >> QUAD_SH);
			default:                      est = NW'(prod >> YEAR_SH);
		endcase
	end

	assign fix = (rem_q >= NW'(dvs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == P_FIX) && !fix;
			case (phase_q)
				P_IDLE:  if (start) phase_q <= P_EST;
				P_EST:   phase_q <= P_BACK;
				P_BACK:  phase_q <= P_FIX;
				P_FIX:   if (!fix) phase_q <= P_IDLE;
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && start) begin
			num_q <= dividend;
			dvs_q <= divisor;
		end
		if (phase_q == P_EST)
			quo_q <= est;
		if (phase_q == P_BACK)
			rem_q <= num_q - NW'(prod);
		if (phase_q == P_FIX && fix) begin
			quo_q <= quo_q + NW'(1);
			rem_q <= rem_q - NW'(dvs_q);
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q[VW-1:0];

endmodule

>>> hdl/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// four divisions by the shared reciprocal unit, each an estimate, a back product and compare
// and subtract correction steps, then the era product, the day of year and the final
// state finish the date
// throughput: one transaction at a time; a new one is taken while the last result waits;
// reset: arst_n clears the sequencers and the result valid only
// depends on gdad_pkg, gdad_if and gdad_div

module gregorian_date_add_days #(
	parameter int DAYS_WIDTH = gdad_pkg::DAYS_WIDTH_DEF,
	parameter int YEAR_WIDTH = gdad_pkg::YEAR_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	gdad_in_if.sink       req,
	gdad_out_if.source    rsp
);

	localparam int NW  = ((DAYS_WIDTH > gdad_pkg::DNUM_WIDTH) ? DAYS_WIDTH
		: gdad_pkg::DNUM_WIDTH) + 1;
	localparam int EW  = NW - 17;
	localparam int YW  = EW + 10;
	localparam int CW  = (YW > YEAR_WIDTH) ? YW : YEAR_WIDTH;
	localparam int VW  = gdad_pkg::DOE_WIDTH;
	localparam int FEW = gdad_pkg::ERA_FWD_WIDTH;
	localparam int PW  = FEW + 18;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ISS_YY   = 4'd1;
	localparam logic [3:0] S_W_YY     = 4'd2;
	localparam logic [3:0] S_MUL      = 4'd3;
	localparam logic [3:0] S_ISS_N    = 4'd4;
	localparam logic [3:0] S_W_N      = 4'd5;
	localparam logic [3:0] S_ISS_QUAD = 4'd6;
	localparam logic [3:0] S_W_QUAD   = 4'd7;
	localparam logic [3:0] S_ISS_YEAR = 4'd8;
	localparam logic [3:0] S_W_YEAR   = 4'd9;
	localparam logic [3:0] S_DOY      = 4'd10;
	localparam logic [3:0] S_FIN      = 4'd11;

	logic [3:0]                                state_q;
	logic [3:0]                                state_d;

	logic [DAYS_WIDTH-1:0]                     add_q;
	logic [gdad_pkg::DAY_WIDTH-1:0]            day_q;
	logic [gdad_pkg::MONTH_WIDTH-1:0]          mp_q;
	logic                                      early_q;
	logic [gdad_pkg::START_YEAR_WIDTH-1:0]     year_q;
	logic [FEW-1:0]                            era_f_q;
	logic [PW-1:0]                             prod_q;
	logic [VW-1:0]                             doe_q;
	logic [EW-1:0]                             era_q;
	logic [VW-1:0]                             x_q;
	logic [gdad_pkg::YOE_WIDTH-1:0]            yoe_q;
	logic [gdad_pkg::DOY_WIDTH-1:0]            doy_q;
	logic [EW+8:0]                             ybase_q;

	logic                                      out_valid_q;
	logic [gdad_pkg::DAY_WIDTH-1:0]            out_day_q;
	logic [gdad_pkg::MONTH_WIDTH-1:0]          out_month_q;
	logic [YEAR_WIDTH-1:0]                     out_year_q;

	logic                                      div_start;
	logic [NW-1:0]                             div_dividend;
	logic [VW-1:0]                             div_divisor;
	logic                                      div_done;
	logic [NW-1:0]                             div_quot;
	logic [VW-1:0]                             div_rem;

	logic                                      accept;
	logic                                      out_free;
	logic [gdad_pkg::DAY_WIDTH-1:0]            in_day;
	logic [gdad_pkg::MONTH_WIDTH-1:0]          in_month;
	logic [gdad_pkg::DOY_WIDTH-1:0]            doy_fwd;
	logic [gdad_pkg::MONTH_WIDTH-1:0]          fin_mp;
	logic [gdad_pkg::DAY_WIDTH-1:0]            fin_day;
	logic [gdad_pkg::MONTH_WIDTH-1:0]          fin_month;
	logic [YW-1:0]                             fin_year;
	logic [CW-1:0]                             fin_year_ext;
	logic [CW-1:0]                             year_max_ext;

	gdad_div #(
		.NW (NW),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	// clamp a zero day to 1 and the month field to 1..12
	always_comb begin
		in_day = (req.start_day == '0) ? gdad_pkg::DAY_WIDTH'(1) : req.start_day;
		if (req.start_month == '0)
			in_month = gdad_pkg::MONTH_WIDTH'(1);
		else if (req.start_month > gdad_pkg::MONTH_WIDTH'(gdad_pkg::MONTHS))
			in_month = gdad_pkg::MONTH_WIDTH'(gdad_pkg::MONTHS);
		else
			in_month = req.start_month;
	end

	assign doy_fwd = gdad_pkg::month_off(mp_q) + gdad_pkg::DOY_WIDTH'(day_q) - 9'd1;

	// divider operand select
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			S_ISS_YY: begin
				div_start    = 1'b1;
				div_dividend = NW'(year_q) + NW'(gdad_pkg::YEAR_SHIFT) - NW'(early_q);
				div_divisor  = VW'(gdad_pkg::ERA_YEARS);
			end
			S_ISS_N: begin
				div_start    = 1'b1;
				div_dividend = NW'(prod_q) + NW'(doe_q) + NW'(add_q);
				div_divisor  = VW'(gdad_pkg::ERA_DAYS);
			end
			S_ISS_QUAD: begin
				div_start    = 1'b1;
				div_dividend = NW'(doe_q);
				div_divisor  = VW'(gdad_pkg::DAYS_PER_QUAD);
			end
			S_ISS_YEAR: begin
				div_start    = 1'b1;
				div_dividend = NW'(x_q);
				div_divisor  = VW'(gdad_pkg::DAYS_PER_YEAR);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (accept) state_d = S_ISS_YY;
			S_ISS_YY:   state_d = S_W_YY;
			S_W_YY:     if (div_done) state_d = S_MUL;
			S_MUL:      state_d = S_ISS_N;
			S_ISS_N:    state_d = S_W_N;
			S_W_N:      if (div_done) state_d = S_ISS_QUAD;
			S_ISS_QUAD: state_d = S_W_QUAD;
			S_W_QUAD:   if (div_done) state_d = S_ISS_YEAR;
			S_ISS_YEAR: state_d = S_W_YEAR;
			S_W_YEAR:   if (div_done) state_d = S_DOY;
			S_DOY:      state_d = S_FIN;
			S_FIN:      if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// final date from year of era and day of year
	always_comb begin
		fin_mp    = gdad_pkg::month_of_doy(doy_q);
		fin_day   = gdad_pkg::DAY_WIDTH'(doy_q - gdad_pkg::month_off(fin_mp) + 9'd1);
		fin_month = (fin_mp < 4'd10) ? fin_mp + 4'd3 : fin_mp - 4'd9;
		fin_year  = YW'(ybase_q) + YW'(yoe_q) + YW'(fin_mp >= 4'd10)
			- YW'(gdad_pkg::YEAR_SHIFT);
		fin_year_ext = CW'(fin_year);
		year_max_ext = CW'({YEAR_WIDTH{1'b1}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			add_q   <= req.days_to_add;
			day_q   <= in_day;
			mp_q    <= (in_month >= 4'd3) ? in_month - 4'd3 : in_month + 4'd9;
			early_q <= (in_month <= 4'd2);
			year_q  <= req.start_year;
		end
		if (state_q == S_W_YY && div_done) begin
			era_f_q <= div_quot[FEW-1:0];
			doe_q   <= gdad_pkg::yoe_days(div_rem[gdad_pkg::YOE_WIDTH-1:0])
				+ VW'(doy_fwd);
		end
		if (state_q == S_MUL)
			prod_q <= PW'(era_f_q) * PW'(gdad_pkg::ERA_DAYS);
		if (state_q == S_W_N && div_done) begin
			era_q <= div_quot[EW-1:0];
			doe_q <= div_rem;
		end
		// leap corrections of the era: one per four years, back per century
		if (state_q == S_W_QUAD && div_done)
			x_q <= doe_q - VW'(div_quot[6:0]) + VW'(gdad_pkg::cent_of_doe(doe_q))
				- VW'(doe_q >= VW'(gdad_pkg::ERA_DAYS - 1));
		if (state_q == S_W_YEAR && div_done)
			yoe_q <= div_quot[gdad_pkg::YOE_WIDTH-1:0];
		if (state_q == S_DOY) begin
			doy_q   <= gdad_pkg::DOY_WIDTH'(doe_q - gdad_pkg::yoe_days(yoe_q));
			ybase_q <= (EW+9)'(era_q) * (EW+9)'(gdad_pkg::ERA_YEARS);
		end
		if (state_q == S_FIN && out_free) begin
			if (fin_year_ext > year_max_ext) begin
				out_day_q   <= gdad_pkg::DAY_WIDTH'(31);
				out_month_q <= gdad_pkg::MONTH_WIDTH'(gdad_pkg::MONTHS);
				out_year_q  <= {YEAR_WIDTH{1'b1}};
			end else begin
				out_day_q   <= fin_day;
				out_month_q <= fin_month;
				out_year_q  <= fin_year_ext[YEAR_WIDTH-1:0];
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.end_day   = out_day_q;
	assign rsp.end_month = out_month_q;
	assign rsp.end_year  = out_year_q;

endmodule
